// File: hw/rtl/lztd_pkg.sv
// ----------------------------------------------------------------------------
// lztd_pkg
// Shared types and constants for the LZ77 token decompressor.
// ----------------------------------------------------------------------------
package lztd_pkg;

  localparam int WIN_DEPTH  = 32768;
  localparam int WIN_AW     = $clog2(WIN_DEPTH);
  localparam int PROD_W     = $clog2(WIN_DEPTH + 1);
  localparam int PTR_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int LB_W       = 3;
  localparam int LEN_W      = 5;
  localparam int FIFO_DEPTH = 2;

  localparam logic [LB_W-1:0] LB_RESET = 3'd3;
  localparam logic [LB_W-1:0] LB_MIN   = 3'd1;
  localparam logic [LB_W-1:0] LB_MAX   = 3'd5;

  // Where the byte of an issued slot comes from once it reaches the write stage
  typedef enum logic [1:0] {
    SRC_RAM  = 2'd0,
    SRC_PREV = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LIT  = 2'd3
  } src_t;

  typedef struct packed {
    src_t              src;
    logic              last;
    logic              bad;
    logic [BYTE_W-1:0] lit;
    logic [WIN_AW-1:0] waddr;
  } issue_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              bad;
  } out_item_t;

endpackage

// File: hw/rtl/lztd_ram.sv
// ----------------------------------------------------------------------------
// lztd_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lztd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/lztd_fifo.sv
// ----------------------------------------------------------------------------
// lztd_fifo
// Small output queue that decouples the write stage from the result channel.
// ----------------------------------------------------------------------------
module lztd_fifo
  import lztd_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  out_item_t                       push_item,
  input  logic                            pop,
  output out_item_t                       head_item,
  output logic                            not_empty,
  output logic [$clog2(FIFO_DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  out_item_t       slot_r [FIFO_DEPTH];
  logic [PW-1:0]   head_r, head_nxt;
  logic [PW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = (tail_r == PW'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (pop) begin
      head_nxt = (head_r == PW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      slot_r[tail_r] <= push_item;
    end
  end

  assign head_item = slot_r[head_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule

// File: hw/rtl/lztd_seq.sv
// ----------------------------------------------------------------------------
// lztd_seq
// Token sequencer: decodes a token, then issues one window slot per cycle while can_issue allows.
// ----------------------------------------------------------------------------
module lztd_seq
  import lztd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LB_W-1:0]   cfg_lb,
  input  logic              tok_valid,
  output logic              tok_ready,
  input  logic [PTR_W-1:0]  tok_ptr,
  input  logic [BYTE_W-1:0] tok_lit,
  input  logic              can_issue,
  output logic              issue_valid,
  output issue_t            issue_item,
  output logic              rd_en,
  output logic [WIN_AW-1:0] rd_addr
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COPY,
    S_LIT
  } state_t;

  localparam int DW = PTR_W - 1;

  state_t             state_r, state_nxt;
  logic [LB_W-1:0]    lb_r;
  logic [LB_W-1:0]    lb_c;
  logic [DW-1:0]      dist_w;
  logic [LEN_W-1:0]   lenm1_w;
  logic               bad_w;
  logic [DW-1:0]      dist_r, dist_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic               bad_r, bad_nxt;
  logic [BYTE_W-1:0]  lit_r, lit_nxt;
  logic [WIN_AW-1:0]  wp_r, wp_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               fire;
  logic [PROD_W:0]    back_sum;
  logic [PROD_W:0]    back_fix;

  // clamp the length field width to its meaningful range
  always_comb begin
    lb_c = lb_r;
    if (lb_r < LB_MIN) begin
      lb_c = LB_MIN;
    end else if (lb_r > LB_MAX) begin
      lb_c = LB_MAX;
    end
  end

  assign dist_w  = DW'(tok_ptr >> lb_c);
  assign lenm1_w = LEN_W'(tok_ptr & ((PTR_W'(1) << lb_c) - PTR_W'(1)));
  assign bad_w   = (PROD_W'(dist_w) > prod_r);

  // read slot: (wp - dist) modulo the window depth
  assign back_sum = (PROD_W+1)'(wp_r) + (PROD_W+1)'(WIN_DEPTH) - (PROD_W+1)'(dist_r);
  assign back_fix = (back_sum >= (PROD_W+1)'(WIN_DEPTH)) ?
                    back_sum - (PROD_W+1)'(WIN_DEPTH) : back_sum;
  assign rd_addr  = back_fix[WIN_AW-1:0];

  assign tok_ready   = (state_r == S_IDLE);
  assign fire        = can_issue && (state_r != S_IDLE);
  assign issue_valid = fire;
  assign rd_en       = fire && (state_r == S_COPY);

  always_comb begin
    issue_item       = '0;
    issue_item.bad   = bad_r;
    issue_item.lit   = lit_r;
    issue_item.waddr = wp_r;
    if (state_r == S_LIT) begin
      issue_item.src  = SRC_LIT;
      issue_item.last = 1'b1;
    end else if (bad_r) begin
      issue_item.src = SRC_ZERO;
    end else if (dist_r == DW'(1)) begin
      issue_item.src = SRC_PREV;
    end else begin
      issue_item.src = SRC_RAM;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dist_nxt  = dist_r;
    cnt_nxt   = cnt_r;
    bad_nxt   = bad_r;
    lit_nxt   = lit_r;
    wp_nxt    = wp_r;
    prod_nxt  = prod_r;
    unique case (state_r)
      S_IDLE: begin
        if (tok_valid) begin
          dist_nxt  = dist_w;
          cnt_nxt   = lenm1_w;
          bad_nxt   = bad_w;
          lit_nxt   = tok_lit;
          state_nxt = (dist_w != '0) ? S_COPY : S_LIT;
        end
      end
      S_COPY: begin
        if (fire) begin
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_nxt = S_LIT;
          end
        end
      end
      S_LIT: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (fire) begin
      wp_nxt = (wp_r == WIN_AW'(WIN_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (prod_r != PROD_W'(WIN_DEPTH)) begin
        prod_nxt = prod_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      prod_r  <= '0;
      lb_r    <= LB_RESET;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      prod_r  <= prod_nxt;
      if (cfg_we) begin
        lb_r <= cfg_lb;
      end
    end
    dist_r <= dist_nxt;
    cnt_r  <= cnt_nxt;
    bad_r  <= bad_nxt;
    lit_r  <= lit_nxt;
  end

endmodule

// File: hw/rtl/lz77_token_decompressor.sv
// ----------------------------------------------------------------------------
// lz77_token_decompressor
// LZ77 token decoder with a 32 KiB history window held in one RAM.
// ----------------------------------------------------------------------------
// One token enters per in_ transfer; it yields (length + 1) bytes on out_
// when its distance is nonzero and a single literal byte otherwise. The
// sequencer first decodes the token, then issues one window slot per cycle
// through the history RAM's single read and single write port while the
// result queue has room; the next token is taken only once every slot of
// the current one is issued. Each byte passes the write-back stage register
// and then the result queue before it reaches out_. Within a token bytes
// leave at one per cycle while out_tready stays high, with a gap between
// tokens while the next one is decoded. A stalled out_ holds the sequencer
// once the two-entry result queue and the write-back stage hold two bytes
// between them. The literal closes each token and carries tlast; tuser flags
// every byte of a token whose distance reached past the bytes written so far
// (those copy bytes read as zero). A distance of one repeats the previous
// byte out of a forwarding register instead of the RAM. The window needs no
// clearing pass: a legal distance only reaches written entries. The user
// must write length_bits on the cfg_ port only while the block is idle;
// the block itself does not enforce this.
module lz77_token_decompressor
  import lztd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration write: length_bits
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LB_W-1:0]    cfg_data,
  // tokens: [15:0] pointer_word, [23:16] literal_byte
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [23:0]        in_tdata,
  // bytes: [7:0] data_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [BYTE_W-1:0]  out_tdata,
  output logic               out_tlast,
  // [0] bad_reference
  output logic               out_tuser
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic              issue_valid;
  issue_t            issue_item;
  logic              rd_en;
  logic [WIN_AW-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              can_issue;

  logic              wb_valid_r;
  issue_t            wb_item_r;
  logic [BYTE_W-1:0] prev_byte_r;
  logic [BYTE_W-1:0] wb_byte;

  out_item_t         push_item;
  out_item_t         head_item;
  logic              pop;
  logic [CW-1:0]     fifo_cnt;
  logic [CW:0]       occupancy;

  // Config writes are always taken; a write affects only tokens decoded after it.
  assign cfg_ready = 1'b1;

  lztd_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid),
    .cfg_lb      (cfg_data),
    .tok_valid   (in_tvalid),
    .tok_ready   (in_tready),
    .tok_ptr     (in_tdata[15:0]),
    .tok_lit     (in_tdata[23:16]),
    .can_issue   (can_issue),
    .issue_valid (issue_valid),
    .issue_item  (issue_item),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  // History window: read in the issue cycle, written back in the cycle after.
  lztd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WIN_DEPTH)
  ) u_win (
    .clk   (clk),
    .we    (wb_valid_r),
    .waddr (wb_item_r.waddr),
    .wdata (wb_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Write-back stage: pick the byte, store it in the window, queue it.
  // A distance of one would read the slot being written this same cycle,
  // so take it from the last stored byte instead.
  always_comb begin
    case (wb_item_r.src)
      SRC_RAM:  wb_byte = rd_data;
      SRC_PREV: wb_byte = prev_byte_r;
      SRC_ZERO: wb_byte = '0;
      SRC_LIT:  wb_byte = wb_item_r.lit;
      default:  wb_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else begin
      wb_valid_r <= issue_valid;
    end
    if (issue_valid) begin
      wb_item_r <= issue_item;
    end
    if (wb_valid_r) begin
      prev_byte_r <= wb_byte;
    end
  end

  assign push_item.data = wb_byte;
  assign push_item.last = wb_item_r.last;
  assign push_item.bad  = wb_item_r.bad;

  // Issue only when the queue is sure to have room for the slot in flight.
  assign pop       = out_tvalid && out_tready;
  assign occupancy = (CW+1)'(fifo_cnt) + (CW+1)'(wb_valid_r);
  assign can_issue = (occupancy < ((CW+1)'(FIFO_DEPTH) + (CW+1)'(pop)));

  lztd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (wb_valid_r),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .not_empty (out_tvalid),
    .count     (fifo_cnt)
  );

  assign out_tdata = head_item.data;
  assign out_tlast = head_item.last;
  assign out_tuser = head_item.bad;

endmodule

// File: hw/rtl/lztd_checker.sv
// ----------------------------------------------------------------------------
// lztd_checker
// Port-level checks for the LZ77 token decompressor, bound to the top level.
// ----------------------------------------------------------------------------
module lztd_checker
  import lztd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [BYTE_W-1:0] out_tdata,
  input logic              out_tlast,
  input logic              out_tuser
);

  // a token transfer keeps the input busy in the cycle right after it
  a_busy_after_token: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after a token transfer");

  // reset drains the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled result changed");

  // the config port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind lz77_token_decompressor lztd_checker u_lztd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
